>>> rtl/lir_pkg.sv
// Shared types, constants and the Q15 interpolation function of the resampler.
package lir_pkg;

    localparam int PHASE_W      = 38;
    localparam int STEP_W       = 37;
    localparam int FRAC_W       = 15;
    localparam int FRAC_LSB     = 17;
    localparam int CHAN_W       = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int MAX_CHANNELS = 2;

    localparam logic signed [PHASE_W-1:0] ONE_FRAME  = 38'sd4294967296;
    localparam logic [STEP_W-1:0]         STEP_FLOOR = 37'd67108864;
    localparam logic [STEP_W-1:0]         STEP_RESET = 37'd4294967296;
    localparam logic [CHAN_W-1:0]         CHAN_RESET = 2'd2;
    localparam logic [CHAN_W-1:0]         CHAN_STEREO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [15:0] sample_ch0;
        logic signed [15:0] sample_ch1;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] out_ch0;
        logic signed [15:0] out_ch1;
        logic               last_of_run;
    } t_out_beat;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic restart;
        logic prime;
        logic start_run;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic chan_ok;
        logic have_prev;
        logic phase_neg;
        logic out_free;
        logic last_emit;
    } t_status;

    // y = a + floor((b - a) * f / 2^15), wrapped to 16 bits.
    function automatic logic signed [15:0] lerp_q15(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic [FRAC_W-1:0]  f
    );
        logic signed [16:0] diff;
        logic signed [32:0] prod;
        logic signed [17:0] q;
        logic signed [17:0] sum;
        diff = {b[15], b} - {a[15], a};
        prod = diff * $signed({1'b0, f});
        q    = 18'(prod >>> FRAC_W);
        sum  = q + 18'(a);
        return sum[15:0];
    endfunction

endpackage

>>> rtl/lir_ctrl.sv
// Controller of the resampler: accepts frames and sequences the output run.
module lir_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_func,
    output logic            o_in_stall,
    input  lir_pkg::t_status i_status,
    output lir_pkg::t_cmd    o_cmd
);
    import lir_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    priority if (i_in_func == FUNC_RESTART) begin
                        o_cmd.restart = 1'b1;
                    end else if (!i_status.chan_ok) begin
                        // Invalid channel count: the frame is dropped untouched.
                    end else if (i_status.have_prev && i_status.phase_neg) begin
                        o_cmd.start_run = 1'b1;
                        n_state         = ST_RUN;
                    end else begin
                        o_cmd.prime = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_emit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/lir_dp.sv
// Datapath of the resampler: configuration, phase, frame store and output register.
module lir_dp #(
    parameter int MAX_CHANNELS = lir_pkg::MAX_CHANNELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lir_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lir_pkg::STEP_W-1:0]        i_cfg_data,
    input  lir_pkg::t_in_beat                 i_in_data,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output lir_pkg::t_out_beat                o_out_data,
    input  lir_pkg::t_cmd                     i_cmd,
    output lir_pkg::t_status                  o_status
);
    import lir_pkg::*;

    logic [STEP_W-1:0]         r_phase_step;
    logic [CHAN_W-1:0]         r_chan_cnt;
    logic signed [15:0]        r_prev0;
    logic signed [15:0]        r_prev1;
    logic signed [15:0]        r_cur0;
    logic signed [15:0]        r_cur1;
    logic                      r_have_prev;
    logic signed [PHASE_W-1:0] r_phase;
    logic                      r_out_valid;
    t_out_beat                 r_out;

    logic [STEP_W-1:0]         step;
    logic signed [PHASE_W-1:0] phase_next;
    logic signed [PHASE_W-1:0] base_back;
    logic signed [PHASE_W-1:0] phase_back;
    logic                      stereo;
    logic [FRAC_W-1:0]         frac;

    assign step       = (r_phase_step < STEP_FLOOR) ? STEP_FLOOR : r_phase_step;
    assign phase_next = r_phase + $signed({1'b0, step});
    assign stereo     = (r_chan_cnt == CHAN_STEREO) && (MAX_CHANNELS >= 2);
    assign frac       = r_phase[FRAC_LSB +: FRAC_W];

    // Move the phase back by one frame, never below minus one frame.
    assign base_back  = (i_cmd.emit ? phase_next : r_phase) - ONE_FRAME;
    assign phase_back = (base_back < -ONE_FRAME) ? -ONE_FRAME : base_back;

    assign o_status.chan_ok   = (r_chan_cnt != '0) && (32'(r_chan_cnt) <= MAX_CHANNELS);
    assign o_status.have_prev = r_have_prev;
    assign o_status.phase_neg = r_phase[PHASE_W-1];
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_status.last_emit = !phase_next[PHASE_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= STEP_RESET;
            r_chan_cnt   <= CHAN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:    r_phase_step <= i_cfg_data;
                CFG_CHANNEL_COUNT: r_chan_cnt   <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev0     <= '0;
            r_prev1     <= '0;
            r_have_prev <= 1'b0;
            r_phase     <= '0;
        end else if (i_cmd.restart) begin
            r_prev0     <= '0;
            r_prev1     <= '0;
            r_have_prev <= 1'b0;
            r_phase     <= '0;
        end else if (i_cmd.prime) begin
            r_prev0 <= i_in_data.sample_ch0;
            if (stereo) begin
                r_prev1 <= i_in_data.sample_ch1;
            end
            r_have_prev <= 1'b1;
            r_phase     <= phase_back;
        end else if (i_cmd.emit) begin
            if (o_status.last_emit) begin
                r_prev0 <= r_cur0;
                if (stereo) begin
                    r_prev1 <= r_cur1;
                end
                r_phase <= phase_back;
            end else begin
                r_phase <= phase_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_run) begin
            r_cur0 <= i_in_data.sample_ch0;
            r_cur1 <= i_in_data.sample_ch1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_ch0     <= lerp_q15(r_prev0, r_cur0, frac);
            r_out.out_ch1     <= stereo ? lerp_q15(r_prev1, r_cur1, frac) : 16'sd0;
            r_out.last_of_run <= o_status.last_emit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/linear_interp_resampler.sv
// Top level of the linear-interpolation sample-rate converter.
//
// Input frames arrive on the in channel (valid/stall); func selects a sample
// frame or a restart. Each sample frame yields zero or more interpolated
// output frames on the out channel, the final one of a run marked by
// last_of_run. The configuration port writes phase_step (index 0) and
// channel_count (index 1); the user must write them only while the block
// is idle: the block itself does not enforce it. A frame that produces N
// outputs is stored, then the run emits one interpolated output per cycle,
// while the receiver does not stall, into the output register. N is at most
// 64 and is set by the phase step. Restarts, priming frames and other frames
// that produce no output end without a run. The output register lets the
// next frame be accepted while the last output of a run still waits.
// When the receiver stalls, the run pauses with the output held steady.
// Reset clears the phase, the stored previous frame and the output valid
// flag and restores phase_step to one frame and channel_count to two.
module linear_interp_resampler #(
    parameter int MAX_CHANNELS = lir_pkg::MAX_CHANNELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lir_pkg::t_in_beat             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lir_pkg::t_out_beat            o_out_data,
    input  logic                          i_cfg_wr_en,
    input  logic [lir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lir_pkg::STEP_W-1:0]    i_cfg_data
);
    import lir_pkg::*;

    t_cmd    cmd;
    t_status status;

    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_data.func),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lir_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
